// ----- sv/tss_pkg.sv -----
// Shared types and constants of the task state scheduler.
package tss_pkg;

    // Table size and owner width
    localparam int TASK_SLOTS = 16;
    localparam int OWNER_BITS = 8;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int CMP_W  = ((SLOT_W > 4) ? SLOT_W : 4) + 1;
    localparam int SUM_W  = CNT_W + 2;

    // Request kinds
    typedef enum logic [1:0] {
        M_CREATE = 2'd0,
        M_BLOCK  = 2'd1,
        M_WAKE   = 2'd2,
        M_KILL   = 2'd3
    } t_mode;

    // Slot states
    typedef enum logic [1:0] {
        SL_FREE  = 2'd0,
        SL_RUN   = 2'd1,
        SL_BLOCK = 2'd2,
        SL_READY = 2'd3
    } t_slot_st;

    // Response codes
    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_EMPTY   = 4'd1,
        ST_ALLBLK  = 4'd2,
        ST_NOBLK   = 4'd3,
        ST_OWNER   = 4'd4,
        ST_FREE    = 4'd5,
        ST_STATE   = 4'd6,
        ST_BADID   = 4'd7,
        ST_REFUSED = 4'd8,
        ST_FULL    = 4'd9
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_REMOVE,
        S_DISP,
        S_HEAD,
        S_FINISH
    } t_state;

    // Slot table write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        t_slot_st          st;
    } t_tbl_wr;

endpackage

// ----- sv/tss_intf.sv -----
// Request and response channel interfaces of the task state scheduler.
interface tss_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] owner;
    logic [3:0] task_slot;
    logic       admit;

    modport source (output valid, mode, owner, task_slot, admit, input ready);
    modport sink   (input valid, mode, owner, task_slot, admit, output ready);
endinterface

interface tss_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [3:0] new_task;
    logic       run_valid;
    logic [3:0] run_task;

    modport source (output valid, status, new_task, run_valid, run_task, input ready);
    modport sink   (input valid, status, new_task, run_valid, run_task, output ready);
endinterface

// ----- sv/tss_ram.sv -----
// Generic one-write one-read RAM with registered read data.
module tss_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tss_slot_tbl.sv -----
// Slot state table: one state per slot in flops, cleared to free at reset.
module tss_slot_tbl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tss_pkg::SLOT_W-1:0]  i_rd_idx,
    output tss_pkg::t_slot_st           o_rd_st,
    input  tss_pkg::t_tbl_wr            i_wr
);

    tss_pkg::t_slot_st r_st [tss_pkg::TASK_SLOTS];

    // State update, all slots free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tss_pkg::TASK_SLOTS; k++) begin
                r_st[k] <= tss_pkg::SL_FREE;
            end
        end else if (i_wr.en) begin
            r_st[i_wr.idx] <= i_wr.st;
        end
    end

    // Single read port at the sequencer's index
    assign o_rd_st = r_st[i_rd_idx];

endmodule

// ----- sv/task_state_scheduler_core.sv -----
// Top level of the task state scheduler: request sequencer over slot table and ready list.
// A request is taken in IDLE; an admitted create scans FIND for the lowest free slot, others
// pass CHECK and a ready-list removal walks REMOVE; DISP then fetches the ready head via HEAD
// and walks REMOVE to dispatch it if nothing runs, at most one list walk per request; FINISH
// loads the response. One request at a time; a stalled response holds FINISH.
// Reset: synchronous, active low; all slots free, counters zero, nothing running.
module task_state_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tss_req_if.sink     i_req,
    tss_rsp_if.source   o_rsp
);

    localparam int SW = tss_pkg::SLOT_W;
    localparam int CW = tss_pkg::CNT_W;
    localparam int OW = tss_pkg::OWNER_BITS;

    tss_pkg::t_state  r_state, n_state;
    tss_pkg::t_mode   r_mode, n_mode;
    tss_pkg::t_status r_status, n_status;
    logic [OW-1:0]    r_owner, n_owner;
    logic [3:0]       r_slot_in, n_slot_in;
    logic [SW-1:0]    r_idx, n_idx;
    logic [SW-1:0]    r_new, n_new;
    logic [CW-1:0]    r_rdy_cnt, n_rdy_cnt;
    logic [CW-1:0]    r_blk_cnt, n_blk_cnt;
    logic             r_run, n_run;
    logic [SW-1:0]    r_run_slot, n_run_slot;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [SW-1:0]    r_pos, n_pos;
    logic             r_iss, n_iss;
    logic             r_dv, n_dv;
    logic             r_found, n_found;
    logic [SW-1:0]    r_tgt, n_tgt;
    logic             r_disp, n_disp;
    logic             r_out_vld, n_out_vld;
    logic [3:0]       r_out_status, n_out_status;
    logic [3:0]       r_out_new, n_out_new;
    logic             r_out_run, n_out_run;
    logic [3:0]       r_out_run_task, n_out_run_task;

    tss_pkg::t_tbl_wr  tbl_wr;
    tss_pkg::t_slot_st tbl_st;
    logic              own_we;
    logic [OW-1:0]     own_rdata;
    logic              lst_we;
    logic [SW-1:0]     lst_waddr;
    logic [SW-1:0]     lst_wdata;
    logic [SW-1:0]     lst_raddr;
    logic [SW-1:0]     lst_rdata;
    logic [CW-1:0]     cnt_m1;
    logic              is_empty;
    logic              bad_id;

    // Slot state table
    tss_slot_tbl u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd_st  (tbl_st),
        .i_wr     (tbl_wr)
    );

    // Owner store, read at the incoming slot so the data is there in CHECK
    tss_ram #(.DATA_W(OW), .DEPTH(tss_pkg::TASK_SLOTS)) u_owner (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (r_idx),
        .i_wdata (r_owner),
        .i_raddr (SW'(i_req.task_slot)),
        .o_rdata (own_rdata)
    );

    // Ready list in FIFO order
    tss_ram #(.DATA_W(SW), .DEPTH(tss_pkg::TASK_SLOTS)) u_list (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (lst_wdata),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

    assign cnt_m1   = r_rdy_cnt - CW'(1);
    assign is_empty = !r_run && (r_rdy_cnt == '0) && (r_blk_cnt == '0);
    assign bad_id   = (tss_pkg::CMP_W'(r_slot_in) >=
                       tss_pkg::CMP_W'(tss_pkg::TASK_SLOTS));

    assign i_req.ready     = (r_state == tss_pkg::S_IDLE);
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.new_task  = r_out_new;
    assign o_rsp.run_valid = r_out_run;
    assign o_rsp.run_task  = r_out_run_task;

    // Sequencer: next state and datapath control
    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_status       = r_status;
        n_owner        = r_owner;
        n_slot_in      = r_slot_in;
        n_idx          = r_idx;
        n_new          = r_new;
        n_rdy_cnt      = r_rdy_cnt;
        n_blk_cnt      = r_blk_cnt;
        n_run          = r_run;
        n_run_slot     = r_run_slot;
        n_ptr          = r_ptr;
        n_pos          = r_pos;
        n_iss          = r_iss;
        n_dv           = r_dv;
        n_found        = r_found;
        n_tgt          = r_tgt;
        n_disp         = r_disp;
        n_out_vld      = r_out_vld;
        n_out_status   = r_out_status;
        n_out_new      = r_out_new;
        n_out_run      = r_out_run;
        n_out_run_task = r_out_run_task;
        tbl_wr         = '0;
        own_we         = 1'b0;
        lst_we         = 1'b0;
        lst_waddr      = '0;
        lst_wdata      = '0;
        lst_raddr      = '0;

        // Output beat taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            tss_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_mode    = tss_pkg::t_mode'(i_req.mode);
                    n_owner   = OW'(i_req.owner);
                    n_slot_in = i_req.task_slot;
                    n_idx     = SW'(i_req.task_slot);
                    n_new     = '0;
                    n_status  = tss_pkg::ST_OK;
                    if (tss_pkg::t_mode'(i_req.mode) == tss_pkg::M_CREATE) begin
                        if (!i_req.admit) begin
                            n_status = tss_pkg::ST_REFUSED;
                            n_state  = tss_pkg::S_DISP;
                        end else begin
                            n_idx   = '0;
                            n_state = tss_pkg::S_FIND;
                        end
                    end else begin
                        n_state = tss_pkg::S_CHECK;
                    end
                end
            end

            // Scan for the lowest free slot
            tss_pkg::S_FIND: begin
                if (tbl_st == tss_pkg::SL_FREE) begin
                    tbl_wr.en  = 1'b1;
                    tbl_wr.idx = r_idx;
                    tbl_wr.st  = tss_pkg::SL_READY;
                    own_we     = 1'b1;
                    lst_we     = 1'b1;
                    lst_waddr  = SW'(r_rdy_cnt);
                    lst_wdata  = r_idx;
                    n_rdy_cnt  = r_rdy_cnt + CW'(1);
                    n_new      = r_idx;
                    n_status   = tss_pkg::ST_OK;
                    n_state    = tss_pkg::S_DISP;
                end else if (r_idx == SW'(tss_pkg::TASK_SLOTS - 1)) begin
                    n_status = tss_pkg::ST_FULL;
                    n_state  = tss_pkg::S_DISP;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end

            // Checks in priority order, then the state change
            tss_pkg::S_CHECK: begin
                n_state = tss_pkg::S_DISP;
                n_tgt   = r_idx;
                n_disp  = 1'b0;
                n_ptr   = '0;
                n_iss   = 1'b1;
                n_dv    = 1'b0;
                n_found = 1'b0;
                if (is_empty) begin
                    n_status = tss_pkg::ST_EMPTY;
                end else if (r_mode == tss_pkg::M_BLOCK && !r_run && r_rdy_cnt == '0) begin
                    n_status = tss_pkg::ST_ALLBLK;
                end else if (r_mode == tss_pkg::M_WAKE && r_blk_cnt == '0) begin
                    n_status = tss_pkg::ST_NOBLK;
                end else if (bad_id) begin
                    n_status = tss_pkg::ST_BADID;
                end else if (own_rdata != r_owner) begin
                    n_status = tss_pkg::ST_OWNER;
                end else if (tbl_st == tss_pkg::SL_FREE) begin
                    n_status = tss_pkg::ST_FREE;
                end else begin
                    tbl_wr.idx = r_idx;
                    unique case (r_mode)
                        tss_pkg::M_BLOCK: begin
                            if (tbl_st == tss_pkg::SL_BLOCK) begin
                                n_status = tss_pkg::ST_STATE;
                            end else begin
                                tbl_wr.en = 1'b1;
                                tbl_wr.st = tss_pkg::SL_BLOCK;
                                n_blk_cnt = r_blk_cnt + CW'(1);
                                if (tbl_st == tss_pkg::SL_RUN) begin
                                    n_run = 1'b0;
                                end else begin
                                    n_state = tss_pkg::S_REMOVE;
                                end
                            end
                        end
                        tss_pkg::M_WAKE: begin
                            if (tbl_st != tss_pkg::SL_BLOCK) begin
                                n_status = tss_pkg::ST_STATE;
                            end else begin
                                tbl_wr.en = 1'b1;
                                tbl_wr.st = tss_pkg::SL_READY;
                                if (r_blk_cnt != '0) begin
                                    n_blk_cnt = r_blk_cnt - CW'(1);
                                end
                                lst_we    = 1'b1;
                                lst_waddr = SW'(r_rdy_cnt);
                                lst_wdata = r_idx;
                                n_rdy_cnt = r_rdy_cnt + CW'(1);
                            end
                        end
                        tss_pkg::M_KILL: begin
                            tbl_wr.en = 1'b1;
                            tbl_wr.st = tss_pkg::SL_FREE;
                            if (tbl_st == tss_pkg::SL_RUN) begin
                                n_run = 1'b0;
                            end else if (tbl_st == tss_pkg::SL_BLOCK) begin
                                if (r_blk_cnt != '0) begin
                                    n_blk_cnt = r_blk_cnt - CW'(1);
                                end
                            end else begin
                                n_state = tss_pkg::S_REMOVE;
                            end
                        end
                        default: begin
                            n_state = tss_pkg::S_DISP;
                        end
                    endcase
                end
            end

            // Walk the ready list: find the target, then shift later entries down
            tss_pkg::S_REMOVE: begin
                lst_raddr = r_ptr;
                if (r_iss) begin
                    n_dv  = 1'b1;
                    n_pos = r_ptr;
                    if (CW'(r_ptr) == cnt_m1) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ptr = r_ptr + SW'(1);
                    end
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (r_found) begin
                        lst_we    = 1'b1;
                        lst_waddr = r_pos - SW'(1);
                        lst_wdata = lst_rdata;
                    end else if (lst_rdata == r_tgt) begin
                        n_found = 1'b1;
                    end
                    if (CW'(r_pos) == cnt_m1) begin
                        n_rdy_cnt = cnt_m1;
                        n_iss     = 1'b0;
                        n_dv      = 1'b0;
                        if (r_disp) begin
                            tbl_wr.en  = 1'b1;
                            tbl_wr.idx = r_tgt;
                            tbl_wr.st  = tss_pkg::SL_RUN;
                            n_run      = 1'b1;
                            n_run_slot = r_tgt;
                            n_state    = tss_pkg::S_FINISH;
                        end else begin
                            n_state = tss_pkg::S_DISP;
                        end
                    end
                end
            end

            // Nothing running and the ready list not empty: fetch the ready head, else finish
            tss_pkg::S_DISP: begin
                lst_raddr = '0;
                if (!r_run && r_rdy_cnt != '0) begin
                    n_state = tss_pkg::S_HEAD;
                end else begin
                    n_state = tss_pkg::S_FINISH;
                end
            end

            tss_pkg::S_HEAD: begin
                n_tgt   = lst_rdata;
                n_disp  = 1'b1;
                n_ptr   = '0;
                n_iss   = 1'b1;
                n_dv    = 1'b0;
                n_found = 1'b0;
                n_state = tss_pkg::S_REMOVE;
            end

            // Load the response register once it is free
            tss_pkg::S_FINISH: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld      = 1'b1;
                    n_out_status   = r_status;
                    n_out_new      = 4'(r_new);
                    n_out_run      = r_run;
                    n_out_run_task = r_run ? 4'(r_run_slot) : 4'd0;
                    n_state        = tss_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tss_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tss_pkg::S_IDLE;
            r_rdy_cnt  <= '0;
            r_blk_cnt  <= '0;
            r_run      <= 1'b0;
            r_run_slot <= '0;
            r_iss      <= 1'b0;
            r_dv       <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rdy_cnt  <= n_rdy_cnt;
            r_blk_cnt  <= n_blk_cnt;
            r_run      <= n_run;
            r_run_slot <= n_run_slot;
            r_iss      <= n_iss;
            r_dv       <= n_dv;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_mode         <= n_mode;
        r_status       <= n_status;
        r_owner        <= n_owner;
        r_slot_in      <= n_slot_in;
        r_idx          <= n_idx;
        r_new          <= n_new;
        r_ptr          <= n_ptr;
        r_pos          <= n_pos;
        r_found        <= n_found;
        r_tgt          <= n_tgt;
        r_disp         <= n_disp;
        r_out_status   <= n_out_status;
        r_out_new      <= n_out_new;
        r_out_run      <= n_out_run;
        r_out_run_task <= n_out_run_task;
    end

    // A finished list walk always removes exactly one entry
    a_remove_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == tss_pkg::S_REMOVE && r_state != tss_pkg::S_REMOVE)
            |-> (r_rdy_cnt == $past(r_rdy_cnt) - CW'(1)))
        else $error("ready count not decremented by list walk");

    // Ready, blocked and running tasks never outnumber the slots
    a_task_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tss_pkg::S_CHECK) |->
            ((tss_pkg::SUM_W'(r_rdy_cnt) + tss_pkg::SUM_W'(r_blk_cnt) +
              tss_pkg::SUM_W'(r_run)) <= tss_pkg::SUM_W'(tss_pkg::TASK_SLOTS)))
        else $error("task counts exceed table size");

    // A walk never starts on an empty ready list
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tss_pkg::S_REMOVE) |-> (r_rdy_cnt != '0))
        else $error("ready list walk on empty list");

endmodule

// ----- verif/tss_outcome_check.sv -----
// Response predictor and comparator for the task state scheduler testbench.
module tss_outcome_check
    import tss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tss_req_if         i_req,
    tss_rsp_if         i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output logic [9:0] o_status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status    status;
        logic [3:0] new_task;
        logic       run_valid;
        logic [3:0] run_task;
    } t_sched_rsp;

    // Shadow task table
    t_slot_st              slot_st  [TASK_SLOTS];
    logic [OWNER_BITS-1:0] slot_own [TASK_SLOTS];
    logic [SLOT_W-1:0]     ready_fifo [$];
    int                    blocked_n;
    logic                  run_on;
    logic [SLOT_W-1:0]     run_id;

    // Responses still owed by the block, oldest first
    t_sched_rsp rsp_expect [$];
    t_sched_rsp want;
    int         fails;
    int         checked;
    logic [9:0] seen;

    // Take a slot out of the ready order wherever it stands
    function automatic void drop_ready(logic [SLOT_W-1:0] s);
        for (int i = 0; i < ready_fifo.size(); i++) begin
            if (ready_fifo[i] == s) begin
                ready_fifo.delete(i);
                return;
            end
        end
    endfunction

    // Apply one request to the shadow table and return the response it earns
    function automatic t_sched_rsp schedule_request(t_mode mode, logic [7:0] owner,
                                                    logic [3:0] slot, logic admit);
        t_sched_rsp            r;
        logic [OWNER_BITS-1:0] own;
        bit                    no_tasks;
        int                    idx;
        t_slot_st              cur;
        r        = '0;
        r.status = ST_OK;
        own      = owner[OWNER_BITS-1:0];
        no_tasks = !run_on && ready_fifo.size() == 0 && blocked_n == 0;
        idx      = int'(slot);

        if (mode == M_CREATE) begin
            if (!admit) begin
                r.status = ST_REFUSED;
            end else begin
                r.status = ST_FULL;
                // lowest free slot wins
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (slot_st[i] == SL_FREE) begin
                        slot_st[i]  = SL_READY;
                        slot_own[i] = own;
                        ready_fifo.insert(ready_fifo.size(), SLOT_W'(i));
                        r.new_task  = 4'(i);
                        r.status    = ST_OK;
                        break;
                    end
                end
            end
        end else if (no_tasks) begin
            r.status = ST_EMPTY;
        end else if (mode == M_BLOCK && !run_on && ready_fifo.size() == 0) begin
            r.status = ST_ALLBLK;
        end else if (mode == M_WAKE && blocked_n == 0) begin
            r.status = ST_NOBLK;
        end else if (idx >= TASK_SLOTS) begin
            r.status = ST_BADID;
        end else if (slot_own[idx] != own) begin
            r.status = ST_OWNER;
        end else if (slot_st[idx] == SL_FREE) begin
            r.status = ST_FREE;
        end else begin
            cur = slot_st[idx];
            case (mode)
                M_BLOCK: begin
                    if (cur == SL_BLOCK) begin
                        r.status = ST_STATE;
                    end else begin
                        if (cur == SL_RUN) run_on = 1'b0;
                        else drop_ready(SLOT_W'(idx));
                        slot_st[idx] = SL_BLOCK;
                        blocked_n++;
                    end
                end
                M_WAKE: begin
                    if (cur != SL_BLOCK) begin
                        r.status = ST_STATE;
                    end else begin
                        slot_st[idx] = SL_READY;
                        if (blocked_n > 0) blocked_n--;
                        ready_fifo.insert(ready_fifo.size(), SLOT_W'(idx));
                    end
                end
                default: begin
                    // kill frees the slot from any live state
                    if (cur == SL_RUN) run_on = 1'b0;
                    else if (cur == SL_BLOCK) begin
                        if (blocked_n > 0) blocked_n--;
                    end else drop_ready(SLOT_W'(idx));
                    slot_st[idx] = SL_FREE;
                end
            endcase
        end

        // idle processor picks up the ready head
        if (!run_on && ready_fifo.size() > 0) begin
            run_id          = ready_fifo.pop_front();
            slot_st[run_id] = SL_RUN;
            run_on          = 1'b1;
        end
        r.run_valid = run_on;
        r.run_task  = run_on ? 4'(run_id) : 4'd0;
        return r;
    endfunction

    // Predict on request beats, compare on response beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                slot_st[i]  = SL_FREE;
                slot_own[i] = '0;
            end
            ready_fifo.delete();
            rsp_expect.delete();
            blocked_n = 0;
            run_on    = 1'b0;
            run_id    = '0;
            fails     = 0;
            checked   = 0;
            seen      = '0;
        end else begin
            if (i_req.valid && i_req.ready)
                rsp_expect.insert(rsp_expect.size(),
                                  schedule_request(t_mode'(i_req.mode), i_req.owner,
                                                   i_req.task_slot, i_req.admit));
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_expect.size() == 0) begin
                    $display("%0t: response beat with nothing outstanding: status %0d",
                             $time, i_rsp.status);
                    fails++;
                end else begin
                    want = rsp_expect.pop_front();
                    checked++;
                    if (i_rsp.status <= 4'd9) seen[i_rsp.status] = 1'b1;
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d (%s) actual %0d", $time,
                                 want.status, want.status.name(), i_rsp.status);
                        fails++;
                    end
                    if (i_rsp.new_task !== want.new_task) begin
                        $display("%0t: new_task expected %0d actual %0d", $time,
                                 want.new_task, i_rsp.new_task);
                        fails++;
                    end
                    if (i_rsp.run_valid !== want.run_valid) begin
                        $display("%0t: run_valid expected %0b actual %0b", $time,
                                 want.run_valid, i_rsp.run_valid);
                        fails++;
                    end
                    if (i_rsp.run_task !== want.run_task) begin
                        $display("%0t: run_task expected %0d actual %0d", $time,
                                 want.run_task, i_rsp.run_task);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= rsp_expect.size();
        o_checked     <= checked;
        o_status_seen <= seen;
    end

endmodule

// ----- verif/tb_task_state_scheduler_core.sv -----
// Testbench top for the task state scheduler: clock, reset, request traffic and verdict.
module tb_task_state_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int RANDOM_ITEMS = 1425;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk;
    logic i_rst_n;

    tss_req_if req_ch ();
    tss_rsp_if rsp_ch ();

    int         fail_count;
    int         pending;
    int         checked;
    logic [9:0] status_seen;

    // Requests in flight, used to learn owners of created slots
    typedef struct {
        t_mode      mode;
        logic [7:0] owner;
    } t_issued;

    t_issued    issued_q [$];
    t_issued    done_req;
    logic [7:0] owner_known [TASK_SLOTS];
    int         known_slots;
    int         sent;
    int         burst_left;
    int         rcv_mode;
    int         rcv_left;
    int         cycles;

    task_state_scheduler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tss_outcome_check u_outcome_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached, %0d responses outstanding",
                     CYCLE_LIMIT, pending);
            $display("tb_task_state_scheduler_core: errors");
            $finish;
        end
    end

    // Receiver stall pattern: switches between open, random, slow and square-wave stretches
    always @(posedge i_clk) begin
        if (rcv_left <= 0) begin
            rcv_mode = $urandom_range(0, 3);
            rcv_left = $urandom_range(8, 120);
        end
        rcv_left--;
        case (rcv_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ch.ready <= cycles[2];
        endcase
    end

    // Learn slot owners from completed creates; the created range only grows
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && issued_q.size() > 0) begin
            done_req = issued_q.pop_front();
            if (done_req.mode == M_CREATE && rsp_ch.status == ST_OK) begin
                owner_known[rsp_ch.new_task] = done_req.owner;
                if (int'(rsp_ch.new_task) + 1 > known_slots)
                    known_slots = int'(rsp_ch.new_task) + 1;
            end
        end
    end

    // Send one request beat, then maybe close the burst with a gap
    task automatic issue(input t_mode mode, input logic [7:0] owner,
                         input logic [3:0] slot, input logic admit);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= mode;
        req_ch.owner     <= owner;
        req_ch.task_slot <= slot;
        req_ch.admit     <= admit;
        do @(posedge i_clk); while (!req_ch.ready);
        issued_q.insert(issued_q.size(), t_issued'{mode, owner});
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    function automatic t_mode pick_mode(int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            // fill the table
            0:       return r < 70 ? M_CREATE : r < 80 ? M_BLOCK : r < 90 ? M_WAKE : M_KILL;
            // drain it
            1:       return r < 10 ? M_CREATE : r < 25 ? M_BLOCK : r < 40 ? M_WAKE : M_KILL;
            default: return t_mode'(r % 4);
        endcase
    endfunction

    initial begin
        t_mode      m;
        logic [3:0] s;
        logic [7:0] o;
        logic       a;
        int         phase;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = M_CREATE;
        req_ch.owner     = '0;
        req_ch.task_slot = '0;
        req_ch.admit     = 1'b0;
        rsp_ch.ready     = 1'b0;
        known_slots      = 0;
        sent             = 0;
        cycles           = 0;
        rcv_left         = 0;
        burst_left       = $urandom_range(1, 24);
        phase            = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, refusal, owner and state errors, list removals
        issue(M_BLOCK,  8'h00, 4'd15, 1'b1);   // empty
        issue(M_WAKE,   8'hFF, 4'd0,  1'b0);   // empty
        issue(M_KILL,   8'h80, 4'd7,  1'b1);   // empty
        issue(M_CREATE, 8'h11, 4'd0,  1'b0);   // refused
        issue(M_CREATE, 8'hFF, 4'd9,  1'b1);   // slot 0, runs at once
        issue(M_WAKE,   8'hFF, 4'd0,  1'b1);   // none blocked
        issue(M_BLOCK,  8'h00, 4'd0,  1'b0);   // wrong owner
        issue(M_BLOCK,  8'hFF, 4'd0,  1'b0);   // running task blocks
        issue(M_BLOCK,  8'hFF, 4'd0,  1'b1);   // all blocked
        issue(M_WAKE,   8'hFF, 4'd0,  1'b0);   // wakes and is dispatched
        issue(M_KILL,   8'hFF, 4'd0,  1'b0);   // table empty again
        issue(M_KILL,   8'hFF, 4'd0,  1'b1);   // empty
        issue(M_CREATE, 8'h5A, 4'd3,  1'b1);   // slot 0 runs
        issue(M_CREATE, 8'hA5, 4'd0,  1'b1);   // slot 1 ready
        issue(M_CREATE, 8'h3C, 4'd0,  1'b1);   // slot 2 ready
        issue(M_CREATE, 8'hC3, 4'd0,  1'b1);   // slot 3 ready
        issue(M_KILL,   8'h3C, 4'd2,  1'b0);   // leaves from mid-list
        issue(M_KILL,   8'h3C, 4'd2,  1'b0);   // free slot
        issue(M_BLOCK,  8'hA5, 4'd1,  1'b0);   // ready head blocks
        issue(M_BLOCK,  8'hA5, 4'd1,  1'b1);   // wrong state
        issue(M_WAKE,   8'h5A, 4'd0,  1'b0);   // wrong state, it is running
        issue(M_BLOCK,  8'h5A, 4'd0,  1'b1);   // running blocks, slot 3 dispatched
        issue(M_WAKE,   8'hA5, 4'd1,  1'b0);   // joins the tail
        issue(M_KILL,   8'hC3, 4'd3,  1'b1);   // running killed, slot 1 dispatched
        issue(M_KILL,   8'h5A, 4'd0,  1'b0);   // blocked task killed

        // Random: phases that fill, drain or churn the table
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) phase = $urandom_range(0, 2);
            m = (known_slots == 0) ? M_CREATE : pick_mode(phase);
            if (m == M_CREATE) begin
                s = 4'($urandom_range(0, 15));
                o = 8'($urandom_range(0, 255));
                a = ($urandom_range(0, 9) != 0);
            end else begin
                // only slots known to have been created at least once
                s = 4'($urandom_range(0, known_slots - 1));
                o = ($urandom_range(0, 99) < 85) ? owner_known[s]
                                                 : 8'($urandom_range(0, 255));
                a = 1'($urandom_range(0, 1));
            end
            issue(m, o, s, a);
        end
        req_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d responses compared, %0d slots reached",
                 sent, checked, known_slots);
        $display("status codes returned (bit per code, 9 down to 0): %b", status_seen);
        if (fail_count == 0) begin
            $display("tb_task_state_scheduler_core: clean");
        end else begin
            $display("tb_task_state_scheduler_core: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/tss_pkg.sv
sv/tss_intf.sv
sv/tss_ram.sv
sv/tss_slot_tbl.sv
sv/task_state_scheduler_core.sv
verif/tss_outcome_check.sv
verif/tb_task_state_scheduler_core.sv
